### design/msc_pkg.sv
// Shared types, codes and constants for the MIPS subset step core.
package msc_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int RF_DEPTH = 32;

  localparam logic [31:0] IN_ADDR   = 32'hFFFF000C;
  localparam logic [31:0] OUT_ADDR  = 32'hFFFF0004;
  localparam logic [31:0] RET_RESET = 32'h8123456C;

  // input operation codes
  localparam logic [1:0] OPR_WMEM = 2'd0;
  localparam logic [1:0] OPR_WREG = 2'd1;
  localparam logic [1:0] OPR_EXEC = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_UFETCH  = 3'd2;
  localparam logic [2:0] ST_OOR     = 3'd3;
  localparam logic [2:0] ST_UACCESS = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;
  localparam logic [2:0] ST_WRITE   = 3'd6;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // function codes
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_LIS   = 6'h14;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FETCH, S_EXEC, S_LOAD, S_DIV, S_RESULT
  } state_t;

  typedef enum logic [1:0] {EK_FINISH, EK_LOAD, EK_DIV} ek_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic fetch;
    logic exec;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dec_fetch;
    ek_t  exec_kind;
    logic div_done;
  } sts_t;

  // byte address whose word index lies beyond memory
  function automatic logic word_oor(input logic [31:0] a);
    return a[31:2] >= 30'(MEM_WORDS);
  endfunction

endpackage

### design/msc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/msc_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
module msc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sgn,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic        running;
  logic        fixing;
  logic [4:0]  cnt;
  logic [31:0] ub;
  logic [31:0] q;
  logic [31:0] r;
  logic        na;
  logic        nb;
  logic        dz;
  logic [32:0] sh;
  logic [32:0] diff;
  logic        fits;

  assign sh   = {r, q[31]};
  assign diff = sh - {1'b0, ub};
  assign fits = sh >= {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fixing  <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= fixing;
      if (start) begin
        running <= 1'b1;
      end else if (running && (&cnt)) begin
        running <= 1'b0;
      end
      fixing <= running && (&cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      na  <= sgn && a[31];
      nb  <= sgn && b[31];
      dz  <= (b == '0);
      q   <= (sgn && a[31]) ? (32'd0 - a) : a;
      ub  <= (sgn && b[31]) ? (32'd0 - b) : b;
      r   <= '0;
      cnt <= '0;
    end else if (running) begin
      cnt <= cnt + 5'd1;
      q   <= {q[30:0], fits};
      r   <= fits ? diff[31:0] : sh[31:0];
    end
    if (fixing) begin
      quo <= dz ? '1 : ((na != nb) ? (32'd0 - q) : q);
      rem <= na ? (32'd0 - r) : r;
    end
  end

endmodule

### design/msc_dp.sv
// Datapath: registers, memories, execute logic, multiplier and result registers.
module msc_dp (
  input  logic              clk,
  input  logic              rst,
  input  msc_pkg::cmd_t     cmd,
  output msc_pkg::sts_t     sts,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic [1:0]        operation,
  input  logic [11:0]       word_index,
  input  logic [4:0]        reg_index,
  input  logic [31:0]       write_data,
  input  logic [7:0]        in_char,
  input  logic              in_char_valid,
  output logic [2:0]        status,
  output logic [31:0]       pc_or_address,
  output logic [7:0]        out_char,
  output logic              out_char_valid
);

  logic [1:0]  op_r;
  logic [11:0] widx_r;
  logic [4:0]  ridx_r;
  logic [31:0] wdata_r;
  logic [7:0]  ich_r;
  logic        ichv_r;

  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] ret_addr;
  logic [31:0] gv;
  logic [31:0] ins;
  logic        rsv_r;
  logic        rtv_r;
  logic [4:0]  load_rd;

  logic [2:0]  res_status;
  logic [31:0] res_addr;
  logic [7:0]  res_char;
  logic        res_charv;

  logic                      mem_we;
  logic [msc_pkg::MEM_AW-1:0] mem_waddr;
  logic [31:0]               mem_wdata;
  logic [msc_pkg::MEM_AW-1:0] mem_raddr;
  logic [31:0]               mem_rdata;

  logic        rf_we;
  logic        rf_wr;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [4:0]  rf_ra;
  logic [4:0]  rf_rb;
  logic [31:0] rfa_rdata;
  logic [31:0] rfb_rdata;

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rd;
  logic [4:0]  rt_idx;
  logic [31:0] imm;
  logic [31:0] rs_val;
  logic [31:0] rt_val;
  logic [31:0] nxt;
  logic [31:0] addr;

  logic        msgn;
  logic signed [65:0] prod;

  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] div_rem;

  // execute decisions
  msc_pkg::ek_t              ek;
  logic                      x_rf_we;
  logic [4:0]                x_rf_wa;
  logic [31:0]               x_rf_wd;
  logic                      x_pc_we;
  logic [31:0]               x_pc;
  logic [2:0]                x_st;
  logic [31:0]               x_addr;
  logic [7:0]                x_ch;
  logic                      x_chv;
  logic                      x_mem_we;
  logic                      x_mul;
  logic                      x_div;
  logic [4:0]                x_lrd;
  logic [msc_pkg::MEM_AW-1:0] x_raddr;

  // decode decisions
  logic        dec_fetch;
  logic [2:0]  d_st;

  msc_ram #(.WIDTH(32), .DEPTH(msc_pkg::MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // two copies of the register file give the rs and rt read ports
  msc_ram #(.WIDTH(32), .DEPTH(msc_pkg::RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_wr),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .raddr (rf_ra),
    .rdata (rfa_rdata)
  );

  msc_ram #(.WIDTH(32), .DEPTH(msc_pkg::RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_wr),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .raddr (rf_rb),
    .rdata (rfb_rdata)
  );

  msc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.exec && x_div),
    .a     (rs_val),
    .b     (rt_val),
    .sgn   (fn == msc_pkg::FN_DIV),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign opc    = ins[31:26];
  assign fn     = ins[5:0];
  assign rd     = ins[15:11];
  assign rt_idx = ins[20:16];
  assign imm    = {{16{ins[15]}}, ins[15:0]};
  assign rs_val = rsv_r ? rfa_rdata : '0;
  assign rt_val = rtv_r ? rfb_rdata : '0;
  assign nxt    = pc + 32'd4;
  assign addr   = rs_val + imm;
  assign rf_ra  = mem_rdata[25:21];
  assign rf_rb  = mem_rdata[20:16];

  assign msgn = (fn == msc_pkg::FN_MULT);
  assign prod = $signed({msgn & rs_val[31], rs_val}) * $signed({msgn & rt_val[31], rt_val});

  // decode of the captured item
  assign dec_fetch = (op_r == msc_pkg::OPR_EXEC) && (pc[1:0] == 2'b00) &&
                     (pc != ret_addr) && !msc_pkg::word_oor(pc);

  always_comb begin
    unique case (op_r)
      msc_pkg::OPR_WMEM, msc_pkg::OPR_WREG: d_st = msc_pkg::ST_WRITE;
      msc_pkg::OPR_EXEC: begin
        if (pc[1:0] != 2'b00) begin
          d_st = msc_pkg::ST_UFETCH;
        end else if (pc == ret_addr) begin
          d_st = msc_pkg::ST_DONE;
        end else begin
          d_st = msc_pkg::ST_OOR;
        end
      end
      default: d_st = msc_pkg::ST_INVALID;
    endcase
  end

  // execute of the fetched instruction
  always_comb begin
    ek       = msc_pkg::EK_FINISH;
    x_rf_we  = 1'b0;
    x_rf_wa  = rd;
    x_rf_wd  = '0;
    x_pc_we  = 1'b0;
    x_pc     = nxt;
    x_st     = msc_pkg::ST_OK;
    x_addr   = pc;
    x_ch     = '0;
    x_chv    = 1'b0;
    x_mem_we = 1'b0;
    x_mul    = 1'b0;
    x_div    = 1'b0;
    x_lrd    = rd;
    x_raddr  = nxt[2 +: msc_pkg::MEM_AW];
    unique case (opc)
      msc_pkg::OP_SPECIAL: begin
        unique case (fn)
          msc_pkg::FN_ADD: begin
            x_rf_we = 1'b1; x_rf_wd = rs_val + rt_val; x_pc_we = 1'b1;
          end
          msc_pkg::FN_SUB: begin
            x_rf_we = 1'b1; x_rf_wd = rs_val - rt_val; x_pc_we = 1'b1;
          end
          msc_pkg::FN_MULT, msc_pkg::FN_MULTU: begin
            x_mul = 1'b1; x_pc_we = 1'b1;
          end
          msc_pkg::FN_DIV, msc_pkg::FN_DIVU: begin
            x_div = 1'b1; x_pc_we = 1'b1; ek = msc_pkg::EK_DIV;
          end
          msc_pkg::FN_MFHI: begin
            x_rf_we = 1'b1; x_rf_wd = hi; x_pc_we = 1'b1;
          end
          msc_pkg::FN_MFLO: begin
            x_rf_we = 1'b1; x_rf_wd = lo; x_pc_we = 1'b1;
          end
          msc_pkg::FN_LIS: begin
            if (msc_pkg::word_oor(nxt)) begin
              x_st = msc_pkg::ST_OOR; x_addr = nxt;
            end else begin
              ek = msc_pkg::EK_LOAD; x_pc_we = 1'b1; x_pc = nxt + 32'd4;
            end
          end
          msc_pkg::FN_SLT: begin
            x_rf_we = 1'b1; x_pc_we = 1'b1;
            x_rf_wd = {31'd0, $signed(rs_val) < $signed(rt_val)};
          end
          msc_pkg::FN_SLTU: begin
            x_rf_we = 1'b1; x_pc_we = 1'b1;
            x_rf_wd = {31'd0, rs_val < rt_val};
          end
          msc_pkg::FN_JR: begin
            x_pc_we = 1'b1; x_pc = rs_val;
          end
          msc_pkg::FN_JALR: begin
            x_rf_we = 1'b1; x_rf_wa = 5'd31; x_rf_wd = nxt;
            x_pc_we = 1'b1; x_pc = rs_val;
          end
          default: x_st = msc_pkg::ST_INVALID;
        endcase
      end
      msc_pkg::OP_LW: begin
        if (addr == msc_pkg::IN_ADDR) begin
          x_pc_we = 1'b1;
          x_rf_we = ichv_r; x_rf_wa = rt_idx; x_rf_wd = {24'd0, ich_r};
        end else if (msc_pkg::word_oor(addr)) begin
          x_st = msc_pkg::ST_OOR; x_addr = addr;
        end else if (addr[1:0] != 2'b00) begin
          x_st = msc_pkg::ST_UACCESS; x_addr = addr;
        end else begin
          ek = msc_pkg::EK_LOAD; x_pc_we = 1'b1; x_lrd = rt_idx;
          x_raddr = addr[2 +: msc_pkg::MEM_AW];
        end
      end
      msc_pkg::OP_SW: begin
        if (addr == msc_pkg::OUT_ADDR) begin
          x_pc_we = 1'b1; x_ch = rt_val[7:0]; x_chv = 1'b1;
        end else if (msc_pkg::word_oor(addr)) begin
          x_st = msc_pkg::ST_OOR; x_addr = addr;
        end else if (addr[1:0] != 2'b00) begin
          x_st = msc_pkg::ST_UACCESS; x_addr = addr;
        end else begin
          x_mem_we = 1'b1; x_pc_we = 1'b1;
        end
      end
      msc_pkg::OP_BEQ: begin
        x_pc_we = 1'b1;
        if (rs_val == rt_val) x_pc = nxt + {imm[29:0], 2'b00};
      end
      msc_pkg::OP_BNE: begin
        x_pc_we = 1'b1;
        if (rs_val != rt_val) x_pc = nxt + {imm[29:0], 2'b00};
      end
      default: x_st = msc_pkg::ST_INVALID;
    endcase
    if (x_pc_we) x_addr = x_pc;
  end

  assign sts.dec_fetch = dec_fetch;
  assign sts.exec_kind = ek;
  assign sts.div_done  = div_done;

  // memory port
  assign mem_we = (cmd.decode && (op_r == msc_pkg::OPR_WMEM) &&
                   (32'(widx_r) < 32'(msc_pkg::MEM_WORDS))) ||
                  (cmd.exec && x_mem_we);
  assign mem_waddr = cmd.exec ? addr[2 +: msc_pkg::MEM_AW] : msc_pkg::MEM_AW'(widx_r);
  assign mem_wdata = cmd.exec ? rt_val : wdata_r;
  assign mem_raddr = cmd.exec ? x_raddr : pc[2 +: msc_pkg::MEM_AW];

  // register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_wa = ridx_r;
    rf_wd = wdata_r;
    priority if (cmd.decode && (op_r == msc_pkg::OPR_WREG)) begin
      rf_we = 1'b1;
    end else if (cmd.exec && x_rf_we) begin
      rf_we = 1'b1; rf_wa = x_rf_wa; rf_wd = x_rf_wd;
    end else if (cmd.load) begin
      rf_we = 1'b1; rf_wa = load_rd; rf_wd = mem_rdata;
    end else begin
      rf_we = 1'b0;
    end
  end

  // register zero is never written, so it always reads zero
  assign rf_wr = rf_we && (rf_wa != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      hi       <= '0;
      lo       <= '0;
      ret_addr <= msc_pkg::RET_RESET;
      gv       <= '0;
    end else begin
      if (cfg_we) ret_addr <= cfg_wdata;
      if (rf_wr) gv[rf_wa] <= 1'b1;
      if (cmd.exec && x_pc_we) pc <= x_pc;
      if (cmd.exec && x_mul) begin
        hi <= prod[63:32];
        lo <= prod[31:0];
      end
      if (div_done) begin
        hi <= div_rem;
        lo <= div_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= operation;
      widx_r  <= word_index;
      ridx_r  <= reg_index;
      wdata_r <= write_data;
      ich_r   <= in_char;
      ichv_r  <= in_char_valid;
    end
    if (cmd.fetch) begin
      ins   <= mem_rdata;
      rsv_r <= gv[rf_ra];
      rtv_r <= gv[rf_rb];
    end
    if (cmd.decode) begin
      res_status <= d_st;
      res_addr   <= pc;
      res_char   <= '0;
      res_charv  <= 1'b0;
    end
    if (cmd.exec) begin
      res_status <= x_st;
      res_addr   <= x_addr;
      res_char   <= x_ch;
      res_charv  <= x_chv;
      load_rd    <= x_lrd;
    end
    if (cmd.emit) begin
      status         <= res_status;
      pc_or_address  <= res_addr;
      out_char       <= res_char;
      out_char_valid <= res_charv;
    end
  end

endmodule

### design/msc_ctrl.sv
// Controller: decode, then fetch and execute for instructions, then result.
module msc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output msc_pkg::cmd_t cmd,
  input  msc_pkg::sts_t sts
);

  msc_pkg::state_t state;
  msc_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != msc_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      msc_pkg::S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = msc_pkg::S_DECODE;
      end
      msc_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = sts.dec_fetch ? msc_pkg::S_FETCH : msc_pkg::S_RESULT;
      end
      msc_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = msc_pkg::S_EXEC;
      end
      msc_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.exec_kind)
          msc_pkg::EK_LOAD: state_next = msc_pkg::S_LOAD;
          msc_pkg::EK_DIV:  state_next = msc_pkg::S_DIV;
          default:          state_next = msc_pkg::S_RESULT;
        endcase
      end
      msc_pkg::S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = msc_pkg::S_RESULT;
      end
      msc_pkg::S_DIV: begin
        if (sts.div_done) state_next = msc_pkg::S_RESULT;
      end
      msc_pkg::S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = msc_pkg::S_IDLE;
        end
      end
      default: state_next = msc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### design/mips_subset_core_step_unit.sv
// Top level of the MIPS subset step core: controller, datapath and assertions.
// Items that fetch nothing go from decode to result; instructions also pass fetch
// and execute, memory lw and lis add a load step, div and divu wait on the
// iterative divider (one quotient bit per cycle). One item is in work at a time;
// the next transfer is taken once the result sits in the output register.
// Reset (rst, synchronous): registers, hi, lo and pc clear, return address loads
// 0x8123456C; word memory holds no defined contents until written.
module mips_subset_core_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [11:0] word_index,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [7:0]  in_char,
  input  logic        in_char_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] pc_or_address,
  output logic [7:0]  out_char,
  output logic        out_char_valid
);

  // command and status between controller and datapath
  msc_pkg::cmd_t cmd;
  msc_pkg::sts_t sts;

  // Controller: takes an input transfer in idle, walks decode and, for fetched
  // instructions, fetch and execute, waits on loads and the divider, then hands
  // the result to the output register when it is free.
  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: holds architectural state, memories, the multiplier and the
  // divider, and the output payload registers.
  msc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .operation      (operation),
    .word_index     (word_index),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .in_char        (in_char),
    .in_char_valid  (in_char_valid),
    .status         (status),
    .pc_or_address  (pc_or_address),
    .out_char       (out_char),
    .out_char_valid (out_char_valid)
  );

  // after an input transfer the block holds off further items
  ap_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transfer");

  // a result is loaded only when the output register is free or draining
  ap_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending output");

  // at most one sequencing command at a time
  ap_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.decode, cmd.fetch, cmd.exec, cmd.load, cmd.emit}))
    else $error("overlapping datapath commands");

  // decode always follows a capture
  ap_decode_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.decode |-> $past(cmd.capture))
    else $error("decode without captured item");

endmodule

### test/tb_top.sv
// Self-checking testbench for the MIPS subset step core: directed table, then random programs.
`timescale 1ns / 100ps

module tb_top;
  import msc_pkg::*;

  // operation code 3 is outside the set; the core reports it as invalid
  localparam logic [1:0] OPR_NONE = 2'd3;
  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 50;  // longer than the slowest divide
  localparam int CODE_TOP = 256;     // jump targets stay in the first 256 words
  localparam int N_PHASE_ITEMS = 110;

  // scratch registers the generator keeps pointed at useful places
  localparam logic [4:0] R_IO = 5'd28;    // I/O page base
  localparam logic [4:0] R_DATA = 5'd29;  // data region base
  localparam logic [4:0] R_JUMP = 5'd30;  // jump target

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] widx;
    logic [4:0]  ridx;
    logic [31:0] data;
    logic [7:0]  ch;
    logic        chv;
  } item_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] addr;
    logic [7:0]  ch;
    logic        chv;
  } res_t;

  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [11:0] word_index = '0;
  logic [4:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic [7:0]  in_char = '0;
  logic        in_char_valid = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] pc_or_address;
  logic [7:0]  out_char;
  logic        out_char_valid;

  mips_subset_core_step_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .word_index(word_index), .reg_index(reg_index), .write_data(write_data),
    .in_char(in_char), .in_char_valid(in_char_valid), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .pc_or_address(pc_or_address),
    .out_char(out_char), .out_char_valid(out_char_valid)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted architectural state of the core
  logic [31:0] arch_gpr [32];
  logic [31:0] arch_hi = '0;
  logic [31:0] arch_lo = '0;
  logic [31:0] arch_pc = '0;
  logic [31:0] arch_mem [MEM_WORDS];
  bit          mem_known [MEM_WORDS];
  logic [31:0] ret_addr = RET_RESET;

  res_t status_q [$];  // results still to come, oldest first
  int   n_errors = 0;
  bit   calm = 1'b0;   // when set, neither side idles
  int   hold_reqs = 0; // bumped by the sender to ask the receiver for a long hold-off

  initial begin
    for (int i = 0; i < 32; i++) arch_gpr[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) begin
      arch_mem[i] = '0;
      mem_known[i] = 1'b0;
    end
  end

  // Divide with the core's rules for a zero divisor and signed overflow
  function automatic void divide_words(input logic [31:0] a, input logic [31:0] b,
                                       input bit sgn, output logic [31:0] quo,
                                       output logic [31:0] rem);
    logic [31:0] ua, ub, q, r;
    bit na, nb;
    if (b == 32'd0) begin
      quo = '1;
      rem = a;
      return;
    end
    na = sgn && a[31];
    nb = sgn && b[31];
    ua = na ? 32'd0 - a : a;
    ub = nb ? 32'd0 - b : b;
    q = ua / ub;
    r = ua % ub;
    quo = (na != nb) ? 32'd0 - q : q;
    rem = na ? 32'd0 - r : r;
  endfunction

  // Work out the result of one item. With commit clear the state is left alone,
  // which lets the generator look ahead. need reports a memory word the step would
  // read before anything wrote it (-1 if none).
  function automatic void core_step(input item_t it, input bit commit, output res_t res,
                                    output int need);
    logic [31:0] ins, rsv, rtv, imm, addr, nxt, quo, rem;
    logic [5:0]  opc, fn;
    logic [4:0]  rd, rt;
    longint      prod;
    int          wr_reg;
    logic [31:0] wr_val;
    bit          wr_hilo;
    logic [31:0] new_hi, new_lo;
    int          wr_mem;
    logic [31:0] mem_val;
    need = -1;
    wr_reg = -1;
    wr_val = '0;
    wr_hilo = 1'b0;
    new_hi = '0;
    new_lo = '0;
    wr_mem = -1;
    mem_val = '0;
    res = '{ST_OK, arch_pc, 8'd0, 1'b0};
    if (it.op == OPR_WMEM) begin
      res.st = ST_WRITE;
      if (commit) begin
        arch_mem[it.widx] = it.data;
        mem_known[it.widx] = 1'b1;
      end
      return;
    end
    if (it.op == OPR_WREG) begin
      res.st = ST_WRITE;
      if (commit && it.ridx != 5'd0) arch_gpr[it.ridx] = it.data;
      return;
    end
    if (it.op != OPR_EXEC) begin
      res.st = ST_INVALID;
      return;
    end
    // fetch checks in priority order
    if (arch_pc[1:0] != 2'd0) begin
      res.st = ST_UFETCH;
      return;
    end
    if (arch_pc == ret_addr) begin
      res.st = ST_DONE;
      return;
    end
    if (word_oor(arch_pc)) begin
      res.st = ST_OOR;
      return;
    end
    if (!mem_known[arch_pc[31:2]]) need = int'(arch_pc[31:2]);
    ins = arch_mem[arch_pc[31:2]];
    nxt = arch_pc + 32'd4;
    opc = ins[31:26];
    fn = ins[5:0];
    rsv = arch_gpr[ins[25:21]];
    rt = ins[20:16];
    rtv = arch_gpr[rt];
    rd = ins[15:11];
    imm = {{16{ins[15]}}, ins[15:0]};
    if (opc == OP_SPECIAL) begin
      case (fn)
        FN_ADD: begin wr_reg = rd; wr_val = rsv + rtv; end
        FN_SUB: begin wr_reg = rd; wr_val = rsv - rtv; end
        FN_MULTU: begin
          prod = longint'({32'd0, rsv} * {32'd0, rtv});
          wr_hilo = 1'b1;
          new_hi = prod[63:32];
          new_lo = prod[31:0];
        end
        FN_MULT: begin
          prod = longint'($signed(rsv)) * longint'($signed(rtv));
          wr_hilo = 1'b1;
          new_hi = prod[63:32];
          new_lo = prod[31:0];
        end
        FN_DIV, FN_DIVU: begin
          divide_words(rsv, rtv, fn == FN_DIV, quo, rem);
          wr_hilo = 1'b1;
          new_hi = rem;
          new_lo = quo;
        end
        FN_MFHI: begin wr_reg = rd; wr_val = arch_hi; end
        FN_MFLO: begin wr_reg = rd; wr_val = arch_lo; end
        FN_LIS: begin
          // the literal word follows the instruction
          if (word_oor(nxt)) begin
            res.st = ST_OOR;
            res.addr = nxt;
            return;
          end
          if (need < 0 && !mem_known[nxt[31:2]]) need = int'(nxt[31:2]);
          wr_reg = rd;
          wr_val = arch_mem[nxt[31:2]];
          nxt = nxt + 32'd4;
        end
        FN_SLT: begin wr_reg = rd; wr_val = ($signed(rsv) < $signed(rtv)) ? 32'd1 : 32'd0; end
        FN_SLTU: begin wr_reg = rd; wr_val = (rsv < rtv) ? 32'd1 : 32'd0; end
        FN_JR: nxt = rsv;
        FN_JALR: begin wr_reg = 31; wr_val = nxt; nxt = rsv; end
        default: begin
          res.st = ST_INVALID;
          return;
        end
      endcase
    end else if (opc == OP_LW || opc == OP_SW) begin
      addr = rsv + imm;
      if (opc == OP_LW && addr == IN_ADDR) begin
        if (it.chv) begin wr_reg = rt; wr_val = {24'd0, it.ch}; end
      end else if (opc == OP_SW && addr == OUT_ADDR) begin
        res.ch = rtv[7:0];
        res.chv = 1'b1;
      end else begin
        // range before alignment
        if (word_oor(addr)) begin
          res.st = ST_OOR;
          res.addr = addr;
          return;
        end
        if (addr[1:0] != 2'd0) begin
          res.st = ST_UACCESS;
          res.addr = addr;
          return;
        end
        if (opc == OP_LW) begin
          if (need < 0 && !mem_known[addr[31:2]]) need = int'(addr[31:2]);
          wr_reg = rt;
          wr_val = arch_mem[addr[31:2]];
        end else begin
          wr_mem = int'(addr[31:2]);
          mem_val = rtv;
        end
      end
    end else if (opc == OP_BEQ) begin
      if (rsv == rtv) nxt = nxt + (imm << 2);
    end else if (opc == OP_BNE) begin
      if (rsv != rtv) nxt = nxt + (imm << 2);
    end else begin
      res.st = ST_INVALID;
      return;
    end
    res.addr = nxt;
    if (!commit) return;
    if (wr_reg > 0) arch_gpr[wr_reg] = wr_val;
    if (wr_hilo) begin
      arch_hi = new_hi;
      arch_lo = new_lo;
    end
    if (wr_mem >= 0) begin
      arch_mem[wr_mem] = mem_val;
      mem_known[wr_mem] = 1'b1;
    end
    arch_pc = nxt;
  endfunction

  // Offer one item, wait for its transfer, then record what should come back
  task automatic issue(input item_t it, input bit typed = 1'b0, input res_t fixed = '0);
    res_t res;
    int need;
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    operation <= it.op;
    word_index <= it.widx;
    reg_index <= it.ridx;
    write_data <= it.data;
    in_char <= it.ch;
    in_char_valid <= it.chv;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    core_step(it, 1'b1, res, need);
    status_q.push_back(typed ? fixed : res);
  endtask

  function automatic item_t mem_item(input int idx, input logic [31:0] w);
    return '{OPR_WMEM, 12'(idx), 5'($urandom), w, 8'($urandom), 1'($urandom)};
  endfunction

  function automatic item_t reg_item(input logic [4:0] r, input logic [31:0] d);
    return '{OPR_WREG, 12'($urandom), r, d, 8'($urandom), 1'($urandom)};
  endfunction

  function automatic item_t exec_item();
    return '{OPR_EXEC, 12'($urandom), 5'($urandom), $urandom, 8'($urandom),
             $urandom_range(0, 4) != 0};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 7)) : 5'($urandom_range(0, 31));
  endfunction

  // One random instruction; memory ops lean on the scratch base registers
  function automatic logic [31:0] rand_instr();
    logic [5:0] fns [13];
    logic [4:0] rs, rt;
    logic [15:0] imm;
    int k;
    fns = '{FN_ADD, FN_SUB, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_MFHI, FN_MFLO, FN_LIS,
            FN_SLT, FN_SLTU, FN_JR, FN_JALR};
    rs = pick_reg();
    rt = pick_reg();
    k = $urandom_range(0, 19);
    if (k <= 12) begin
      if (fns[k] == FN_JR || fns[k] == FN_JALR) rs = R_JUMP;
      return {OP_SPECIAL, rs, rt, 5'($urandom_range(0, 27)), 5'($urandom), fns[k]};
    end
    if (k <= 16) begin
      if ($urandom_range(0, 1) == 0) begin
        rs = R_IO;
        imm = (k <= 14) ? IN_ADDR[15:0] : OUT_ADDR[15:0];
      end else begin
        rs = R_DATA;
        imm = 16'($signed($urandom_range(0, 128)) - 64);
      end
      return {(k <= 14) ? OP_LW : OP_SW, rs, rt, imm};
    end
    if (k <= 18) begin
      imm = 16'($signed($urandom_range(0, 16)) - 8);
      return {(k == 17) ? OP_BEQ : OP_BNE, rs, rt, imm};
    end
    return $urandom;
  endfunction

  function automatic bit pc_usable(input logic [31:0] p);
    return p[1:0] == 2'd0 && !word_oor(p);
  endfunction

  // Put at pc an instruction that succeeds and lands on a usable pc, or reads an unwritten word
  task automatic patch_pc();
    logic [31:0] saved, cand;
    bit saved_known;
    res_t res;
    int need, pcw;
    pcw = int'(arch_pc[31:2]);
    saved = arch_mem[pcw];
    saved_known = mem_known[pcw];
    mem_known[pcw] = 1'b1;
    for (int t = 0; t < 16; t++) begin
      cand = rand_instr();
      arch_mem[pcw] = cand;
      core_step(exec_item(), 1'b0, res, need);
      if (need >= 0 || (res.st == ST_OK && pc_usable(res.addr))) begin
        arch_mem[pcw] = saved;
        mem_known[pcw] = saved_known;
        issue(mem_item(pcw, cand));
        return;
      end
    end
    arch_mem[pcw] = saved;
    mem_known[pcw] = saved_known;
    // fall back to a jump through a freshly loaded target
    issue(reg_item(R_JUMP, 32'($urandom_range(0, CODE_TOP - 1)) << 2));
    issue(mem_item(pcw, {OP_SPECIAL, R_JUMP, 10'd0, 5'd0, FN_JR}));
  endtask

  // Execute one step, filling memory ahead of it and steering away from stuck states.
  // Return 1 once the done status was sent.
  task automatic run_step(output bit hit_done);
    item_t it;
    res_t res;
    int need;
    hit_done = 1'b0;
    it = exec_item();
    for (int t = 0; t < 8; t++) begin
      core_step(it, 1'b0, res, need);
      if (need >= 0) begin
        issue(mem_item(need, (need == int'(arch_pc[31:2])) ? rand_instr() : $urandom));
        continue;
      end
      if (res.st == ST_OK && !pc_usable(res.addr)) begin
        patch_pc();
        continue;
      end
      if ((res.st == ST_OOR || res.st == ST_UACCESS || res.st == ST_INVALID) &&
          $urandom_range(0, 3) != 0) begin
        patch_pc();
        continue;
      end
      issue(it);
      hit_done = (res.st == ST_DONE);
      return;
    end
  endtask

  // Drop the offer, let the core drain, then write the return address
  task automatic write_ret(input logic [31:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ret_addr = v;
  endtask

  // Directed rows: register and memory writes, an I/O read and write, divide overflow
  // and divide by zero, a branch back to the start. Typed expectations only where obvious.
  row_t dir_tab [24] = '{
    '{'{OPR_WREG, 12'd0, 5'd0, 32'hFFFFFFFF, 8'h00, 1'b0}, 1'b1, '{ST_WRITE, 32'd0, 8'd0, 1'b0}},
    '{'{OPR_WREG, 12'd0, 5'd31, 32'h00000000, 8'hFF, 1'b1}, 1'b1, '{ST_WRITE, 32'd0, 8'd0, 1'b0}},
    '{'{OPR_WREG, 12'd0, 5'd1, 32'h80000000, 8'h00, 1'b0}, 1'b1, '{ST_WRITE, 32'd0, 8'd0, 1'b0}},
    '{'{OPR_WREG, 12'd0, 5'd2, 32'hFFFFFFFF, 8'h00, 1'b0}, 1'b1, '{ST_WRITE, 32'd0, 8'd0, 1'b0}},
    '{'{OPR_WMEM, 12'hFFF, 5'd0, 32'hFFFFFFFF, 8'h00, 1'b0}, 1'b1, '{ST_WRITE, 32'd0, 8'd0, 1'b0}},
    '{'{OPR_NONE, 12'hFFF, 5'd31, 32'h00000000, 8'hFF, 1'b1}, 1'b1,
      '{ST_INVALID, 32'd0, 8'd0, 1'b0}},
    // program: div r1,r2 / mflo r3 / mfhi r4 / divu r1,r0 / lis r5 + literal /
    // lw r6,0(r5) / sw r1,-8(r5) / beq r0,r0 back to 0
    '{'{OPR_WMEM, 12'd0, 5'd0, 32'h0022001A, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd1, 5'd0, 32'h00001812, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd2, 5'd0, 32'h00002010, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd3, 5'd0, 32'h0020001B, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd4, 5'd0, 32'h00002814, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd5, 5'd0, 32'hFFFF000C, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd6, 5'd0, 32'h8CA60000, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd7, 5'd0, 32'hACA1FFF8, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_WMEM, 12'd8, 5'd0, 32'h1000FFF7, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'hFF, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h00, 1'b0}, 1'b0, '0},
    '{'{OPR_EXEC, 12'd0, 5'd0, 32'd0, 8'h5A, 1'b1}, 1'b0, '0}
  };

  // Stimulus
  initial begin
    logic [31:0] ret_vals [4];
    logic [31:0] d;
    logic [4:0] r;
    bit hit_done;
    int k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs against the reset return address
    foreach (dir_tab[i]) issue(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].exp);

    ret_vals = '{32'hFFFFFFFF, 32'h00000000, 32'($urandom_range(1, 63)) << 2, RET_RESET};
    for (int p = 0; p < 4; p++) begin
      write_ret(ret_vals[p]);
      calm = (p == 2);
      // point the scratch registers somewhere useful
      issue(reg_item(R_IO, 32'hFFFF0000));
      issue(reg_item(R_DATA, 32'h00000400));
      issue(reg_item(R_JUMP, 32'($urandom_range(0, CODE_TOP - 1)) << 2));
      for (int n = 0; n < N_PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering items
        if (p == 0 && n == 20) hold_reqs++;
        k = $urandom_range(0, 99);
        if (k < 12) begin
          r = $urandom_range(0, 31);
          case ($urandom_range(0, 4))
            0: begin r = R_JUMP; d = 32'($urandom_range(0, CODE_TOP - 1)) << 2; end
            1: begin r = R_DATA; d = ($urandom_range(0, 1) != 0) ? 32'h3FC0 : 32'h400; end
            2: begin r = R_IO; d = 32'hFFFF0000; end
            default: d = $urandom;
          endcase
          issue(reg_item(r, d));
        end else if (k < 20) begin
          issue(mem_item($urandom_range(0, MEM_WORDS - 1), $urandom));
        end else if (k < 23) begin
          issue('{OPR_NONE, 12'($urandom), 5'($urandom), $urandom, 8'($urandom), 1'($urandom)});
        end else begin
          run_step(hit_done);
          if (hit_done) begin
            run_step(hit_done);  // done repeats
            break;
          end
        end
      end
    end
    calm = 1'b0;

    // finally jump to a misaligned pc: the fetch fault sticks for good
    issue(reg_item(R_JUMP, 32'h00000002));
    issue(mem_item(int'(arch_pc[31:2]), {OP_SPECIAL, R_JUMP, 10'd0, 5'd0, FN_JR}));
    repeat (3) issue(exec_item());
    @(negedge clk);
    in_valid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("mips_subset_core_step_unit: match");
    end else begin
      $display("mips_subset_core_step_unit: mismatch");
    end
    $finish;
  end

  // Receiver: random stall before each transfer, one long hold-off on request
  initial begin
    int n;
    int seen_holds;
    seen_holds = 0;
    forever begin
      if (hold_reqs != seen_holds) begin
        seen_holds = hold_reqs;
        n = 150;
      end else begin
        n = calm ? 0 : $urandom_range(0, 7);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid || rst);
    end
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result status %0d pc %h", $time, status, pc_or_address);
        n_errors++;
      end else begin
        want = status_q.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, status);
          n_errors++;
        end
        if (pc_or_address !== want.addr) begin
          $display("%0t: pc_or_address expected %h got %h", $time, want.addr, pc_or_address);
          n_errors++;
        end
        if (out_char !== want.ch) begin
          $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
          n_errors++;
        end
        if (out_char_valid !== want.chv) begin
          $display("%0t: out_char_valid expected %b got %b", $time, want.chv, out_char_valid);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("mips_subset_core_step_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
